// ===== hw/rtl/cbm_pkg.sv =====
package cbm_pkg;

   // Item commands; code 3 falls back to translate only
   localparam logic [1:0] CMD_TRANSLATE = 2'd0;
   localparam logic [1:0] CMD_WRITE     = 2'd1;
   localparam logic [1:0] CMD_TICK      = 2'd2;

   // Register space decode
   localparam logic [15:0] ADDR_BASE    = 16'h8000;
   localparam logic [15:0] ADDR_MASK    = 16'hE001;
   localparam logic [15:0] ADDR_MODE    = 16'h8000;
   localparam logic [15:0] ADDR_BANK    = 16'h8001;
   localparam logic [15:0] ADDR_MIRROR  = 16'hA000;
   localparam logic [15:0] ADDR_IRQ_CNT = 16'hC000;
   localparam logic [15:0] ADDR_IRQ_RLD = 16'hC001;
   localparam logic [15:0] ADDR_IRQ_DIS = 16'hE000;
   localparam logic [15:0] ADDR_IRQ_EN  = 16'hE001;

   // Bank value fields
   localparam logic [7:0] BANK_EVEN_MASK = 8'hFE;
   localparam int         MODE_PRG_SWAP  = 6;
   localparam int         MODE_CHR_SWAP  = 7;
   localparam int         CHR_RAM_BIT    = 6;

   // Configuration registers
   localparam int         CSR_INDEX_W      = 1;
   localparam int         CSR_DATA_W       = 9;
   localparam logic [0:0] CSR_PRG_COUNT    = 1'd0;
   localparam logic [0:0] CSR_FOUR_SCREEN  = 1'd1;
   localparam logic [8:0] PRG_COUNT_RESET  = 9'd32;
   localparam logic [8:0] PRG_COUNT_MIN    = 9'd2;
   localparam logic [8:0] PRG_COUNT_MAX    = 9'd256;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        in_vblank;
      logic [1:0]  prg_window;
      logic [2:0]  chr_window;
   } req_type;

   typedef struct packed {
      logic [7:0] prg_bank;
      logic [7:0] chr_bank;
      logic       chr_is_ram;
      logic       irq_pulse;
      logic       mirror_horizontal;
   } rsp_type;

   typedef struct packed {
      logic [7:0][7:0] banks;
      logic [7:0]      mode;
      logic            irq_en;
      logic [7:0]      irq_count;
      logic [7:0]      irq_reload;
      logic            mirror;
   } state_type;

endpackage

// ===== hw/rtl/cbm_if.sv =====
interface cbm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] address;
   logic [7:0]  write_data;
   logic        in_vblank;
   logic [1:0]  prg_window;
   logic [2:0]  chr_window;

   modport source (output valid, command, address, write_data, in_vblank, prg_window,
                   chr_window, input ready);
   modport sink (input valid, command, address, write_data, in_vblank, prg_window,
                 chr_window, output ready);
endinterface

interface cbm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] prg_bank;
   logic [7:0] chr_bank;
   logic       chr_is_ram;
   logic       irq_pulse;
   logic       mirror_horizontal;

   modport source (output valid, prg_bank, chr_bank, chr_is_ram, irq_pulse,
                   mirror_horizontal, input ready);
   modport sink (input valid, prg_bank, chr_bank, chr_is_ram, irq_pulse,
                 mirror_horizontal, output ready);
endinterface

interface cbm_csr_if;
   logic                          valid;
   logic                          ready;
   logic [cbm_pkg::CSR_INDEX_W-1:0] index;
   logic [cbm_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/cbm_ctrl.sv =====
module cbm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                commit,
   input  cbm_pkg::req_type    item,
   input  logic                four_screen,
   output cbm_pkg::state_type  state_nx,
   output logic                pulse
);

   cbm_pkg::state_type state_ff;
   cbm_pkg::state_type state_in;
   logic [15:0]        reg_addr;
   logic [2:0]         sel;

   assign reg_addr = item.address & cbm_pkg::ADDR_MASK;
   assign sel      = state_ff.mode[2:0];

   // Apply one write or tick to the mapper state
   always_comb begin
      state_in = state_ff;
      pulse    = 1'b0;
      case (item.command)
         cbm_pkg::CMD_WRITE: begin
            if (item.address >= cbm_pkg::ADDR_BASE) begin
               case (reg_addr)
                  cbm_pkg::ADDR_MODE: state_in.mode = item.write_data;
                  cbm_pkg::ADDR_BANK: begin
                     state_in.banks[sel] = (sel[2:1] == 2'b00) ?
                        (item.write_data & cbm_pkg::BANK_EVEN_MASK) : item.write_data;
                  end
                  cbm_pkg::ADDR_MIRROR: begin
                     if (!four_screen) state_in.mirror = item.write_data[0];
                  end
                  cbm_pkg::ADDR_IRQ_CNT: state_in.irq_count = item.write_data;
                  cbm_pkg::ADDR_IRQ_RLD: state_in.irq_reload = item.write_data;
                  cbm_pkg::ADDR_IRQ_DIS: begin
                     state_in.irq_en    = 1'b0;
                     state_in.irq_count = state_ff.irq_reload;
                  end
                  cbm_pkg::ADDR_IRQ_EN: state_in.irq_en = 1'b1;
                  default: ;
               endcase
            end
         end
         cbm_pkg::CMD_TICK: begin
            if (!item.in_vblank && state_ff.irq_en) begin
               if (state_ff.irq_count == 8'd0) begin
                  state_in.irq_count = state_ff.irq_reload;
                  pulse              = 1'b1;
               end else begin
                  state_in.irq_count = state_ff.irq_count - 8'd1;
               end
            end
         end
         default: ;
      endcase
   end

   assign state_nx = state_in;

   // Hold state unless an item moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.banks      <= {8'd1, 8'd0, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};
         state_ff.mode       <= 8'd0;
         state_ff.irq_en     <= 1'b0;
         state_ff.irq_count  <= 8'd0;
         state_ff.irq_reload <= 8'd0;
         state_ff.mirror     <= 1'b0;
      end else if (commit) begin
         state_ff <= state_in;
      end
   end

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(state_ff))
      else $error("mapper state changed without a committed request");

   a_pulse_enabled: assert property (@(posedge clock) disable iff (reset)
      pulse |-> state_ff.irq_en && state_ff.irq_count == 8'd0)
      else $error("irq pulse without enabled, expired counter");

endmodule

// ===== hw/rtl/cbm_xlate.sv =====
module cbm_xlate (
   input  cbm_pkg::state_type  state,
   input  logic [8:0]          prg_count,
   input  logic [1:0]          prg_window,
   input  logic [2:0]          chr_window,
   input  logic                pulse,
   output cbm_pkg::rsp_type    rsp
);

   logic [8:0] count_clamped;
   logic [8:0] last_bank;
   logic [8:0] second_last;
   logic [2:0] chr_sel;
   logic [7:0] chr_value;
   logic       prg_sel;

   // Clamp the bank count into its legal range
   always_comb begin
      if (prg_count < cbm_pkg::PRG_COUNT_MIN)      count_clamped = cbm_pkg::PRG_COUNT_MIN;
      else if (prg_count > cbm_pkg::PRG_COUNT_MAX) count_clamped = cbm_pkg::PRG_COUNT_MAX;
      else                                         count_clamped = prg_count;
   end

   assign last_bank   = count_clamped - 9'd1;
   assign second_last = count_clamped - 9'd2;
   assign prg_sel     = prg_window[1] ^ state.mode[cbm_pkg::MODE_PRG_SWAP];

   // Program window lookup
   always_comb begin
      case (prg_window)
         2'd1:    rsp.prg_bank = state.banks[7];
         2'd3:    rsp.prg_bank = last_bank[7:0];
         default: rsp.prg_bank = prg_sel ? second_last[7:0] : state.banks[6];
      endcase
   end

   assign chr_sel = {chr_window[2] ^ state.mode[cbm_pkg::MODE_CHR_SWAP], chr_window[1:0]};

   // Pattern window lookup; 2 KiB banks cover two windows
   always_comb begin
      case (chr_sel)
         3'd0:    chr_value = state.banks[0];
         3'd1:    chr_value = state.banks[0] + 8'd1;
         3'd2:    chr_value = state.banks[1];
         3'd3:    chr_value = state.banks[1] + 8'd1;
         3'd4:    chr_value = state.banks[2];
         3'd5:    chr_value = state.banks[3];
         3'd6:    chr_value = state.banks[4];
         default: chr_value = state.banks[5];
      endcase
   end

   assign rsp.chr_is_ram        = chr_value[cbm_pkg::CHR_RAM_BIT];
   assign rsp.chr_bank          = chr_value[cbm_pkg::CHR_RAM_BIT] ?
                                  {5'd0, chr_value[2:0]} : chr_value;
   assign rsp.irq_pulse         = pulse;
   assign rsp.mirror_horizontal = state.mirror;

endmodule

// ===== hw/rtl/cartridge_bank_mapper_scanline_irq.sv =====
// Cartridge bank mapper with scanline interrupt. Each request is a plain
// translation, a CPU write into the 0x8000-0xFFFF register space, or an
// end-of-scanline tick, and each yields one response with the program and
// pattern banks at the asked windows and the mirroring as they stand after
// the request, plus an irq pulse flag. The block takes one request per clock
// while the result register is free or its response is being taken. A request
// is captured in the input register, where the write or tick and the bank
// lookup are resolved, then loads the result register, which presents the
// response. The input and result registers advance together, so throughput is
// one request per cycle as long as responses are taken. Configuration writes
// are taken at any time and should only be issued while idle.
module cartridge_bank_mapper_scanline_irq (
   input  logic      clock,
   input  logic      reset,
   cbm_req_if.sink   req_ch,
   cbm_rsp_if.source rsp_ch,
   cbm_csr_if.sink   csr_ch
);

   logic               in_valid_ff;
   cbm_pkg::req_type   in_item_ff;
   logic               rsp_valid_ff;
   cbm_pkg::rsp_type   rsp_data_ff;
   cbm_pkg::rsp_type   rsp_data_in;
   cbm_pkg::state_type state_nx;
   logic [8:0]         prg_count_ff;
   logic               four_screen_ff;
   logic               advance;
   logic               commit;
   logic               pulse;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign commit       = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff   <= cbm_pkg::PRG_COUNT_RESET;
         four_screen_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            cbm_pkg::CSR_PRG_COUNT:   prg_count_ff   <= csr_ch.data;
            cbm_pkg::CSR_FOUR_SCREEN: four_screen_ff <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_item_ff.command    <= req_ch.command;
         in_item_ff.address    <= req_ch.address;
         in_item_ff.write_data <= req_ch.write_data;
         in_item_ff.in_vblank  <= req_ch.in_vblank;
         in_item_ff.prg_window <= req_ch.prg_window;
         in_item_ff.chr_window <= req_ch.chr_window;
      end
   end

   cbm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .commit      (commit),
      .item        (in_item_ff),
      .four_screen (four_screen_ff),
      .state_nx    (state_nx),
      .pulse       (pulse)
   );

   cbm_xlate u_xlate (
      .state      (state_nx),
      .prg_count  (prg_count_ff),
      .prg_window (in_item_ff.prg_window),
      .chr_window (in_item_ff.chr_window),
      .pulse      (pulse),
      .rsp        (rsp_data_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.prg_bank          = rsp_data_ff.prg_bank;
   assign rsp_ch.chr_bank          = rsp_data_ff.chr_bank;
   assign rsp_ch.chr_is_ram        = rsp_data_ff.chr_is_ram;
   assign rsp_ch.irq_pulse         = rsp_data_ff.irq_pulse;
   assign rsp_ch.mirror_horizontal = rsp_data_ff.mirror_horizontal;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !in_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   a_ram_bank_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.chr_is_ram |-> rsp_data_ff.chr_bank[7:3] == 5'd0)
      else $error("pattern RAM bank out of range");

   a_pulse_from_tick: assert property (@(posedge clock) disable iff (reset)
      commit && rsp_data_in.irq_pulse |-> in_item_ff.command == cbm_pkg::CMD_TICK)
      else $error("irq pulse from a non-tick request");

endmodule

// ===== tb/sv/tb_cartridge_bank_mapper_scanline_irq.sv =====
module tb_cartridge_bank_mapper_scanline_irq;
   timeunit 1ns;
   timeprecision 1ps;

   // Codes the package leaves unnamed
   localparam logic [1:0]  CMD_SPARE       = 2'd3;
   localparam logic [15:0] ADDR_SPARE      = 16'hA001;
   localparam logic [15:0] ADDR_ALIAS_BITS = ~cbm_pkg::ADDR_MASK;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 305;
   localparam int PHASE_COUNT   = 6;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 4;

   typedef struct {
      cbm_pkg::req_type req;
      bit               typed;
      cbm_pkg::rsp_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   cbm_req_if req_ch ();
   cbm_rsp_if rsp_ch ();
   cbm_csr_if csr_ch ();

   cartridge_bank_mapper_scanline_irq i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Mapper shadow state and configuration
   logic [8:0] cfg_prg_count;
   logic       cfg_four_screen;
   logic [7:0] pm_mode;
   logic [7:0] pm_banks [8];
   logic       pm_irq_en;
   logic [7:0] pm_irq_count;
   logic [7:0] pm_irq_reload;
   logic       pm_mirror;

   cbm_pkg::rsp_type pending_maps [$];
   stim_row_type     directed_rows [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;

   // Free-running clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   task automatic reset_predictor();
      cfg_prg_count   = cbm_pkg::PRG_COUNT_RESET;
      cfg_four_screen = 1'b0;
      pm_mode         = '0;
      pm_banks        = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1};
      pm_irq_en       = 1'b0;
      pm_irq_count    = '0;
      pm_irq_reload   = '0;
      pm_mirror       = 1'b0;
   endtask

   // Apply one request to the shadow state and return the bank lookup
   function automatic cbm_pkg::rsp_type map_request(input cbm_pkg::req_type r);
      logic [8:0]       n;
      logic [8:0]       last;
      logic [8:0]       second;
      logic [1:0]       sel;
      logic [2:0]       w;
      logic [7:0]       cv;
      logic             pulse;
      cbm_pkg::rsp_type o;
      pulse = 1'b0;
      n = (cfg_prg_count < cbm_pkg::PRG_COUNT_MIN) ? cbm_pkg::PRG_COUNT_MIN :
          (cfg_prg_count > cbm_pkg::PRG_COUNT_MAX) ? cbm_pkg::PRG_COUNT_MAX :
          cfg_prg_count;
      last   = n - 9'd1;
      second = n - 9'd2;

      case (r.command)
         cbm_pkg::CMD_WRITE: begin
            if (r.address >= cbm_pkg::ADDR_BASE) begin
               case (r.address & cbm_pkg::ADDR_MASK)
                  cbm_pkg::ADDR_MODE: pm_mode = r.write_data;
                  cbm_pkg::ADDR_BANK: begin
                     if (pm_mode[2:0] < 3'd2)
                        pm_banks[pm_mode[2:0]] = r.write_data & cbm_pkg::BANK_EVEN_MASK;
                     else
                        pm_banks[pm_mode[2:0]] = r.write_data;
                  end
                  cbm_pkg::ADDR_MIRROR: begin
                     if (!cfg_four_screen) pm_mirror = r.write_data[0];
                  end
                  cbm_pkg::ADDR_IRQ_CNT: pm_irq_count = r.write_data;
                  cbm_pkg::ADDR_IRQ_RLD: pm_irq_reload = r.write_data;
                  cbm_pkg::ADDR_IRQ_DIS: begin
                     pm_irq_en    = 1'b0;
                     pm_irq_count = pm_irq_reload;
                  end
                  cbm_pkg::ADDR_IRQ_EN: pm_irq_en = 1'b1;
                  default: ;
               endcase
            end
         end
         cbm_pkg::CMD_TICK: begin
            if (!r.in_vblank && pm_irq_en) begin
               if (pm_irq_count == 8'd0) begin
                  pm_irq_count = pm_irq_reload;
                  pulse = 1'b1;
               end else begin
                  pm_irq_count = pm_irq_count - 8'd1;
               end
            end
         end
         default: ;
      endcase

      // Program window: 1 and 3 are fixed by register 7 and the last bank
      if (r.prg_window == 2'd1) begin
         o.prg_bank = pm_banks[7];
      end else if (r.prg_window == 2'd3) begin
         o.prg_bank = last[7:0];
      end else begin
         sel = r.prg_window ^ {pm_mode[cbm_pkg::MODE_PRG_SWAP], 1'b0};
         o.prg_bank = (sel == 2'd0) ? pm_banks[6] : second[7:0];
      end

      // Pattern window, halves swapped by mode bit 7
      w = r.chr_window ^ {pm_mode[cbm_pkg::MODE_CHR_SWAP], 2'b00};
      case (w)
         3'd0: cv = pm_banks[0];
         3'd1: cv = pm_banks[0] + 8'd1;
         3'd2: cv = pm_banks[1];
         3'd3: cv = pm_banks[1] + 8'd1;
         3'd4: cv = pm_banks[2];
         3'd5: cv = pm_banks[3];
         3'd6: cv = pm_banks[4];
         default: cv = pm_banks[5];
      endcase
      o.chr_is_ram = cv[cbm_pkg::CHR_RAM_BIT];
      o.chr_bank   = cv[cbm_pkg::CHR_RAM_BIT] ? {5'b0, cv[2:0]} : cv;
      o.irq_pulse  = pulse;
      o.mirror_horizontal = pm_mirror;
      return o;
   endfunction

   function automatic cbm_pkg::req_type mk_req(input logic [1:0] cmd,
                                               input logic [15:0] addr,
                                               input logic [7:0] data, input logic vb,
                                               input logic [1:0] pw, input logic [2:0] cw);
      cbm_pkg::req_type r;
      r.command    = cmd;
      r.address    = addr;
      r.write_data = data;
      r.in_vblank  = vb;
      r.prg_window = pw;
      r.chr_window = cw;
      return r;
   endfunction

   function automatic cbm_pkg::rsp_type mk_rsp(input logic [7:0] prg,
                                               input logic [7:0] chr,
                                               input logic ram, input logic irq,
                                               input logic mirror);
      cbm_pkg::rsp_type o;
      o.prg_bank          = prg;
      o.chr_bank          = chr;
      o.chr_is_ram        = ram;
      o.irq_pulse         = irq;
      o.mirror_horizontal = mirror;
      return o;
   endfunction

   // Mostly decoded register writes and ticks, with some noise
   function automatic cbm_pkg::req_type random_request();
      cbm_pkg::req_type r;
      int               pick;
      r.command    = cbm_pkg::CMD_TRANSLATE;
      r.address    = 16'($urandom);
      r.write_data = 8'($urandom);
      r.in_vblank  = ($urandom_range(0, 99) < 20);
      r.prg_window = 2'($urandom);
      r.chr_window = 3'($urandom);
      if ($urandom_range(0, 99) < 10) begin
         r.command = 2'($urandom);
         return r;
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         r.command = cbm_pkg::CMD_TRANSLATE;
      end else if (pick < 60) begin
         r.command = cbm_pkg::CMD_WRITE;
         if ($urandom_range(0, 99) < 15) begin
            r.address = 16'($urandom_range(0, 16'h7FFF));
         end else begin
            case ($urandom_range(0, 7))
               0: r.address = cbm_pkg::ADDR_MODE;
               1: r.address = cbm_pkg::ADDR_BANK;
               2: r.address = cbm_pkg::ADDR_MIRROR;
               3: r.address = cbm_pkg::ADDR_IRQ_CNT;
               4: r.address = cbm_pkg::ADDR_IRQ_RLD;
               5: r.address = cbm_pkg::ADDR_IRQ_DIS;
               6: r.address = cbm_pkg::ADDR_IRQ_EN;
               default: r.address = ADDR_SPARE;
            endcase
            // keep short reload values common so the counter wraps often
            if ((r.address == cbm_pkg::ADDR_IRQ_CNT || r.address == cbm_pkg::ADDR_IRQ_RLD) &&
                $urandom_range(0, 99) < 60)
               r.write_data = 8'($urandom_range(0, 5));
            r.address = r.address | (16'($urandom) & ADDR_ALIAS_BITS);
         end
      end else begin
         r.command = cbm_pkg::CMD_TICK;
      end
      return r;
   endfunction

   // Offer one request and record its expected response on acceptance
   task automatic send_request(input cbm_pkg::req_type r, input bit typed,
                               input cbm_pkg::rsp_type want);
      cbm_pkg::rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= r.command;
      req_ch.address    <= r.address;
      req_ch.write_data <= r.write_data;
      req_ch.in_vblank  <= r.in_vblank;
      req_ch.prg_window <= r.prg_window;
      req_ch.chr_window <= r.chr_window;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = map_request(r);
      pending_maps.push_back(typed ? want : predicted);
   endtask

   // Drop valid and wait until every response is back
   task automatic settle_pipeline();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_maps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [cbm_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [cbm_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      if (idx == cbm_pkg::CSR_PRG_COUNT) cfg_prg_count = value;
      else cfg_four_screen = value[0];
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Response side: random stalls plus requested long hold-offs
   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Compare each response with the oldest expected lookup
   always @(posedge clock) begin
      cbm_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_maps.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_maps.pop_front();
            check_field("prg_bank", rsp_ch.prg_bank, want.prg_bank);
            check_field("chr_bank", rsp_ch.chr_bank, want.chr_bank);
            check_field("chr_is_ram", 8'(rsp_ch.chr_is_ram), 8'(want.chr_is_ram));
            check_field("irq_pulse", 8'(rsp_ch.irq_pulse), 8'(want.irq_pulse));
            check_field("mirror_horizontal", 8'(rsp_ch.mirror_horizontal),
                        8'(want.mirror_horizontal));
         end
      end
   end

   // Main sequence
   initial begin
      int phase_prg_count [PHASE_COUNT];
      int phase_four      [PHASE_COUNT];
      phase_prg_count = '{2, 256, 0, 511, 0, 1};
      phase_four      = '{1, 0, 1, 0, 0, 1};

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.command    = cbm_pkg::CMD_TRANSLATE;
      req_ch.address    = '0;
      req_ch.write_data = '0;
      req_ch.in_vblank  = 1'b0;
      req_ch.prg_window = '0;
      req_ch.chr_window = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = '0;
      csr_ch.data       = '0;
      reset_predictor();

      // Directed: reset map, ignored writes, bank and mode writes, irq wrap
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_TRANSLATE, 16'h0000, 8'h00, 1'b0,
                                       2'd0, 3'd0),
                                1'b1, mk_rsp(8'd0, 8'd0, 1'b0, 1'b0, 1'b0)});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_TRANSLATE, 16'hFFFF, 8'hFF, 1'b1,
                                       2'd3, 3'd7),
                                1'b1, mk_rsp(8'd31, 8'd7, 1'b0, 1'b0, 1'b0)});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_TRANSLATE, 16'h0000, 8'h00, 1'b0,
                                       2'd1, 3'd1),
                                1'b1, mk_rsp(8'd1, 8'd1, 1'b0, 1'b0, 1'b0)});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_TRANSLATE, 16'h0000, 8'h00, 1'b0,
                                       2'd2, 3'd3),
                                1'b1, mk_rsp(8'd30, 8'd3, 1'b0, 1'b0, 1'b0)});
      directed_rows.push_back('{mk_req(CMD_SPARE, 16'h8000, 8'hFF, 1'b0, 2'd1, 3'd4),
                                1'b1, mk_rsp(8'd1, 8'd4, 1'b0, 1'b0, 1'b0)});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_WRITE, 16'h7FFF, 8'hFF, 1'b0,
                                       2'd0, 3'd2),
                                1'b1, mk_rsp(8'd0, 8'd2, 1'b0, 1'b0, 1'b0)});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_TICK, 16'h0000, 8'h00, 1'b0,
                                       2'd0, 3'd5),
                                1'b1, mk_rsp(8'd0, 8'd5, 1'b0, 1'b0, 1'b0)});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_MODE, 8'h47, 1'b0,
                                       2'd0, 3'd0),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_BANK, 8'hFF, 1'b0,
                                       2'd1, 3'd0),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_WRITE, 16'h9FFE, 8'h80, 1'b0,
                                       2'd2, 3'd4),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_BANK, 8'hFF, 1'b0,
                                       2'd0, 3'd4),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_MODE, 8'h05, 1'b0,
                                       2'd0, 3'd7),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_BANK, 8'h43, 1'b0,
                                       2'd3, 3'd7),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_MIRROR, 8'h01,
                                       1'b0, 2'd0, 3'd0),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_WRITE, ADDR_SPARE, 8'h00, 1'b0,
                                       2'd1, 3'd1),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_IRQ_RLD, 8'h02,
                                       1'b0, 2'd2, 3'd2),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_IRQ_CNT, 8'h00,
                                       1'b0, 2'd3, 3'd3),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_WRITE, 16'hFFFF, 8'h00, 1'b0,
                                       2'd0, 3'd4),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_TICK, 16'h0000, 8'h00, 1'b1,
                                       2'd1, 3'd5),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_TICK, 16'h0000, 8'h00, 1'b0,
                                       2'd2, 3'd6),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_TICK, 16'h0000, 8'h00, 1'b0,
                                       2'd3, 3'd7),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_TICK, 16'h0000, 8'h00, 1'b0,
                                       2'd0, 3'd0),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_TICK, 16'h0000, 8'h00, 1'b0,
                                       2'd1, 3'd1),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_IRQ_DIS, 8'h00,
                                       1'b0, 2'd2, 3'd2),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_TICK, 16'h0000, 8'h00, 1'b0,
                                       2'd3, 3'd3),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_MODE, 8'hFF, 1'b0,
                                       2'd3, 3'd3),
                                1'b0, '0});

      // Hold reset, then release on a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      settle_pipeline();

      // Random phases over several configurations and idle patterns
      phase_prg_count[4] = $urandom_range(0, 511);
      phase_four[4]      = $urandom_range(0, 1);
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_register(cbm_pkg::CSR_PRG_COUNT, 9'(phase_prg_count[p]));
         write_register(cbm_pkg::CSR_FOUR_SCREEN, 9'(phase_four[p]));
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         // back up the pipeline once while requests keep coming
         if (p == 4) hold_requests++;
         for (int k = 0; k < PHASE_ITEMS; k++)
            send_request(random_request(), 1'b0, '0);
         settle_pipeline();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
